// File: rtl/core/mbxq_pkg.sv
package mbxq_pkg;

  // fixed field widths
  localparam int unsigned REQ_FW    = 2;
  localparam int unsigned NODE_FW   = 4;
  localparam int unsigned HANDLE_FW = 16;
  localparam int unsigned ACT_FW    = 3;
  localparam int unsigned COUNT_FW  = 7;
  localparam int unsigned CFG_IW    = 2;
  localparam int unsigned CFG_DW    = 16;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned LIMIT_W   = 6;

  // parameter defaults
  localparam int unsigned NODES_DEF       = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam int unsigned HANDLE_BITS_DEF = 16;

  localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RST = 6'd40;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_SELF_ADDRESS = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_MEMBER_MASK  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_QUEUE_LIMIT  = 2'd2;

  typedef enum logic [REQ_FW-1:0] {
    REQ_SEND    = 2'd0,
    REQ_DONE    = 2'd1,
    REQ_RECV    = 2'd2,
    REQ_RELEASE = 2'd3
  } req_e;

  typedef enum logic [ACT_FW-1:0] {
    ACT_QUEUED  = 3'd0,
    ACT_START   = 3'd1,
    ACT_DROP    = 3'd2,
    ACT_DELIVER = 3'd3,
    ACT_ACK     = 3'd4,
    ACT_IDLE    = 3'd5,
    ACT_REJECT  = 3'd6
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EXEC
  } state_e;

endpackage

// File: rtl/core/mbxq_node_mem.sv
module mbxq_node_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 20
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // entries never written read as the reset value, zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// File: rtl/core/mbxq_handle_mem.sv
module mbxq_handle_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: rtl/core/mailbox_send_queue_handshake_unit.sv
// Per-destination send queues of packet handles with a one-slot receive
// mailbox per node. Each accepted transaction returns exactly one result.
// The node state memory is read in the accept cycle, the handle store is
// read at the queue head and the entry after it in the lookup state, and
// the update is written back to both memories in the execute state while
// the result is loaded into the output register; execute holds while a
// stalled result waits there. The input stalls in lookup and execute, so
// a new transaction is accepted only once the last is through; a result
// waiting in the output register does not block the next accept. Node state
// resets at once via per-node valid bits, with no clearing pass; the handle
// store is not cleared and only written entries are used. Configuration must
// be written while no transaction is in flight; the block does not check it.
module mailbox_send_queue_handshake_unit #(
  parameter int unsigned NODES       = mbxq_pkg::NODES_DEF,
  parameter int unsigned QUEUE_DEPTH = mbxq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = mbxq_pkg::HANDLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            cfg_we_i,
  input  logic [mbxq_pkg::CFG_IW-1:0]     cfg_idx_i,
  input  logic [mbxq_pkg::CFG_DW-1:0]     cfg_wdata_i,

  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [mbxq_pkg::REQ_FW-1:0]     req_type_i,
  input  logic [mbxq_pkg::NODE_FW-1:0]    node_i,
  input  logic [mbxq_pkg::HANDLE_FW-1:0]  packet_handle_i,

  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mbxq_pkg::ACT_FW-1:0]     action_o,
  output logic [mbxq_pkg::NODE_FW-1:0]    target_node_o,
  output logic [mbxq_pkg::HANDLE_FW-1:0]  out_handle_o,
  output logic                            freed_valid_o,
  output logic [mbxq_pkg::HANDLE_FW-1:0]  freed_handle_o,
  output logic [mbxq_pkg::COUNT_FW-1:0]   queue_count_o
);

  import mbxq_pkg::*;

  localparam int unsigned NODE_W  = $clog2(NODES);
  localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned HW      = (HANDLE_BITS < HANDLE_FW) ? HANDLE_BITS : HANDLE_FW;
  localparam int unsigned ST_W    = 1 + CNT_W + 2 * PTR_W;
  localparam int unsigned SDEPTH  = NODES * QUEUE_DEPTH;
  localparam int unsigned ADDR_W  = $clog2(SDEPTH);

  // configuration
  logic [NODE_FW-1:0] self_q;
  logic [MASK_W-1:0]  member_q;
  logic [LIMIT_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q   <= '0;
      member_q <= '0;
      limit_q  <= QUEUE_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SELF_ADDRESS: self_q   <= cfg_wdata_i[NODE_FW-1:0];
        CFG_MEMBER_MASK:  member_q <= cfg_wdata_i[MASK_W-1:0];
        CFG_QUEUE_LIMIT:  limit_q  <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  state_e state_q, state_d;
  logic   accept_in;
  logic   exec_fire;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    exec_fire  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        // hold until the output register can take the result
        if (!out_valid_q || !out_stall_i) begin
          exec_fire = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign accept_in = in_valid_i && !in_stall_o;

  // transaction register
  req_e               req_q;
  logic [NODE_FW-1:0] node_q;
  logic [HW-1:0]      handle_q;
  logic [NODE_W-1:0]  node_idx_q;

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      req_q    <= req_e'(req_type_i);
      node_q   <= node_i;
      handle_q <= packet_handle_i[HW-1:0];
    end
  end

  assign node_idx_q = NODE_W'(node_q);

  // node state memory
  logic [ST_W-1:0]  st_rdata;
  logic [ST_W-1:0]  st_wdata;
  logic             st_we;
  logic             recv_r, recv_n;
  logic [CNT_W-1:0] fill_r, fill_n;
  logic [PTR_W-1:0] tail_r, tail_n;
  logic [PTR_W-1:0] head_r, head_n;
  logic [PTR_W-1:0] head_nx;
  logic [PTR_W-1:0] tail_nx;

  mbxq_node_mem #(
    .DEPTH (NODES),
    .WIDTH (ST_W)
  ) u_node_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (st_we),
    .waddr_i (node_idx_q),
    .wdata_i (st_wdata),
    .re_i    (accept_in),
    .raddr_i (NODE_W'(node_i)),
    .rdata_o (st_rdata)
  );

  assign {recv_r, fill_r, tail_r, head_r} = st_rdata;
  assign st_wdata = {recv_n, fill_n, tail_n, head_n};

  assign head_nx = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
  assign tail_nx = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);

  // handle store
  logic [ADDR_W-1:0] base;
  logic              hs_we;
  logic [HW-1:0]     hs_rdata_a;
  logic [HW-1:0]     hs_rdata_b;

  assign base = ADDR_W'(node_idx_q) * ADDR_W'(QUEUE_DEPTH);

  mbxq_handle_mem #(
    .DEPTH (SDEPTH),
    .WIDTH (HW)
  ) u_handle_mem (
    .clk_i     (clk_i),
    .we_i      (hs_we),
    .waddr_i   (base + ADDR_W'(tail_r)),
    .wdata_i   (handle_q),
    .re_i      (state_q == ST_LOOKUP),
    .raddr_a_i (base + ADDR_W'(head_r)),
    .raddr_b_i (base + ADDR_W'(head_nx)),
    .rdata_a_o (hs_rdata_a),
    .rdata_b_o (hs_rdata_b)
  );

  // update
  logic          in_range;
  logic          ok;
  logic          busy;
  logic          full;
  logic          store_wr;
  act_e          act_d;
  logic [HW-1:0] oh_d;
  logic          fv_d;
  logic [HW-1:0] fh_d;

  assign in_range = 32'(node_q) < NODES;
  assign ok       = in_range && (node_q != self_q) && member_q[node_q];
  assign busy     = (fill_r != '0);
  assign full     = (32'(fill_r) > 32'(limit_q)) || (32'(fill_r) >= QUEUE_DEPTH);

  always_comb begin
    act_d    = ACT_REJECT;
    oh_d     = '0;
    fv_d     = 1'b0;
    fh_d     = '0;
    recv_n   = recv_r;
    fill_n   = fill_r;
    tail_n   = tail_r;
    head_n   = head_r;
    store_wr = 1'b0;
    if (ok) begin
      unique case (req_q)
        REQ_SEND: begin
          if (!busy) begin
            store_wr = 1'b1;
            tail_n   = tail_nx;
            fill_n   = CNT_W'(1);
            act_d    = ACT_START;
            oh_d     = handle_q;
          end else if (full) begin
            act_d = ACT_DROP;
            oh_d  = handle_q;
          end else begin
            store_wr = 1'b1;
            tail_n   = tail_nx;
            fill_n   = fill_r + CNT_W'(1);
            act_d    = ACT_QUEUED;
          end
        end
        REQ_DONE: begin
          if (busy) begin
            fv_d   = 1'b1;
            fh_d   = hs_rdata_a;
            head_n = head_nx;
            fill_n = fill_r - CNT_W'(1);
            if (fill_r != CNT_W'(1)) begin
              act_d = ACT_START;
              oh_d  = hs_rdata_b;
            end else begin
              act_d = ACT_IDLE;
            end
          end
        end
        REQ_RECV: begin
          if (!recv_r) begin
            recv_n = 1'b1;
            act_d  = ACT_DELIVER;
          end
        end
        REQ_RELEASE: begin
          if (recv_r) begin
            recv_n = 1'b0;
            act_d  = ACT_ACK;
          end
        end
      endcase
    end
  end

  assign st_we = exec_fire && ok;
  assign hs_we = exec_fire && store_wr;

  // output register
  logic [ACT_FW-1:0]    act_q;
  logic [NODE_FW-1:0]   tnode_q;
  logic [HANDLE_FW-1:0] oh_q;
  logic                 fv_q;
  logic [HANDLE_FW-1:0] fh_q;
  logic [COUNT_FW-1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      act_q   <= act_d;
      tnode_q <= node_q;
      oh_q    <= HANDLE_FW'(oh_d);
      fv_q    <= fv_d;
      fh_q    <= HANDLE_FW'(fh_d);
      cnt_q   <= in_range ? COUNT_FW'(fill_n) : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = act_q;
  assign target_node_o  = tnode_q;
  assign out_handle_o   = oh_q;
  assign freed_valid_o  = fv_q;
  assign freed_handle_o = fh_q;
  assign queue_count_o  = cnt_q;

  // checks
  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> state_q == ST_LOOKUP)
    else $error("accepted transaction did not enter lookup");

  a_exec_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) && out_valid_q && out_stall_i |=> state_q == ST_EXEC)
    else $error("result written over a stalled output");

  a_freed_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && freed_valid_o |-> (action_o == ACT_START || action_o == ACT_IDLE))
    else $error("freed handle with wrong action");

  a_handle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !(action_o == ACT_START || action_o == ACT_DROP)
      |-> out_handle_o == '0)
    else $error("nonzero handle on action without handle");

endmodule
